[rtl/bro_pkg.sv]
package bro_pkg;

  localparam int GRAD_W        = 11;
  localparam int PROD_W        = 23;
  localparam int CROSS_W       = 33;
  localparam int DIFF_W        = 32;
  localparam int OUT_W         = 16;
  localparam int ACC_W         = 32;
  localparam int CW            = 43;
  localparam int NORM_BITS     = 38;
  localparam int NORM_STAGES   = 6;
  localparam int ATAN_LEN      = 24;
  localparam int ANGLE_BITS_DEF = 16;

  typedef struct packed {
    logic                   valid;
    logic                   zero;
    logic signed [CW-1:0]   x;
    logic signed [CW-1:0]   y;
    logic [ACC_W-1:0]       acc;
  } bro_vec_t;

  // Arctangent of 2^-i, with 2^32 units per full turn.
  function automatic logic [ACC_W-1:0] atan_turn(input logic [4:0] idx);
    logic [ACC_W-1:0] t;
    unique case (idx)
      5'd0:    t = 32'h20000000;
      5'd1:    t = 32'h12E4051E;
      5'd2:    t = 32'h09FB385B;
      5'd3:    t = 32'h051111D4;
      5'd4:    t = 32'h028B0D43;
      5'd5:    t = 32'h0145D7E1;
      5'd6:    t = 32'h00A2F61E;
      5'd7:    t = 32'h00517C55;
      5'd8:    t = 32'h0028BE53;
      5'd9:    t = 32'h00145F2F;
      5'd10:   t = 32'h000A2F98;
      5'd11:   t = 32'h000517CC;
      5'd12:   t = 32'h00028BE6;
      5'd13:   t = 32'h000145F3;
      5'd14:   t = 32'h0000A2FA;
      5'd15:   t = 32'h0000517D;
      5'd16:   t = 32'h000028BE;
      5'd17:   t = 32'h0000145F;
      5'd18:   t = 32'h00000A30;
      5'd19:   t = 32'h00000518;
      5'd20:   t = 32'h0000028C;
      5'd21:   t = 32'h00000146;
      5'd22:   t = 32'h000000A3;
      5'd23:   t = 32'h00000051;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

[rtl/bro_in_if.sv]
interface bro_in_if
  import bro_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [GRAD_W-1:0] grad_x;
  logic signed [GRAD_W-1:0] grad_y;
  logic                     last_of_block;

  modport source (output valid, output grad_x, output grad_y, output last_of_block,
                  input ready);
  modport sink (input valid, input grad_x, input grad_y, input last_of_block,
                output ready);
endinterface

[rtl/bro_out_if.sv]
interface bro_out_if
  import bro_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] orientation;

  modport source (output valid, output orientation, input ready);
  modport sink (input valid, input orientation, output ready);
endinterface

[rtl/bro_accum.sv]
module bro_accum
  import bro_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [GRAD_W-1:0] grad_x_i,
  input  logic signed [GRAD_W-1:0] grad_y_i,
  input  logic                     last_i,
  output bro_vec_t                 vec_o
);

  logic signed [2*GRAD_W-1:0] pxy, pxx, pyy;
  logic                       a_valid_q, a_last_q;
  logic signed [PROD_W-1:0]   a_cross_q, a_cross_d, a_diff_q, a_diff_d;

  logic signed [CROSS_W-1:0]  cross_q, cross_d, cross_new;
  logic signed [DIFF_W-1:0]   diff_q, diff_d, diff_new;
  logic signed [CROSS_W:0]    cross_sum;
  logic signed [DIFF_W:0]     diff_sum;
  logic                       l_valid_q, l_valid_d;
  logic signed [DIFF_W-1:0]   l_x_q;
  logic signed [CROSS_W-1:0]  l_y_q;

  bro_vec_t                   vec_q, vec_d;
  logic signed [CW-1:0]       ext_x, ext_y;

  assign pxy       = grad_x_i * grad_y_i;
  assign pxx       = grad_x_i * grad_x_i;
  assign pyy       = grad_y_i * grad_y_i;
  assign a_cross_d = {pxy, 1'b0};
  assign a_diff_d  = PROD_W'(pxx) - PROD_W'(pyy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_last_q  <= last_i;
      a_cross_q <= a_cross_d;
      a_diff_q  <= a_diff_d;
    end
  end

  // Each sum saturates at its own width after every pixel.
  always_comb begin
    cross_sum = (CROSS_W + 1)'(cross_q) + (CROSS_W + 1)'(a_cross_q);
    diff_sum  = (DIFF_W + 1)'(diff_q) + (DIFF_W + 1)'(a_diff_q);
    if (cross_sum[CROSS_W] != cross_sum[CROSS_W-1]) begin
      cross_new = cross_sum[CROSS_W] ? {1'b1, {(CROSS_W-1){1'b0}}}
                                     : {1'b0, {(CROSS_W-1){1'b1}}};
    end else begin
      cross_new = cross_sum[CROSS_W-1:0];
    end
    if (diff_sum[DIFF_W] != diff_sum[DIFF_W-1]) begin
      diff_new = diff_sum[DIFF_W] ? {1'b1, {(DIFF_W-1){1'b0}}}
                                  : {1'b0, {(DIFF_W-1){1'b1}}};
    end else begin
      diff_new = diff_sum[DIFF_W-1:0];
    end
    cross_d   = cross_q;
    diff_d    = diff_q;
    l_valid_d = 1'b0;
    if (a_valid_q) begin
      if (a_last_q) begin
        cross_d   = '0;
        diff_d    = '0;
        l_valid_d = 1'b1;
      end else begin
        cross_d = cross_new;
        diff_d  = diff_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cross_q   <= '0;
      diff_q    <= '0;
      l_valid_q <= 1'b0;
      vec_q     <= '0;
    end else if (en_i) begin
      cross_q   <= cross_d;
      diff_q    <= diff_d;
      l_valid_q <= l_valid_d;
      vec_q     <= vec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l_x_q     <= diff_new;
      l_y_q     <= cross_new;
    end
  end

  // A vector in the left half plane is turned by a half turn first.
  always_comb begin
    ext_x       = CW'(l_x_q);
    ext_y       = CW'(l_y_q);
    vec_d.valid = l_valid_q;
    vec_d.zero  = (l_x_q == '0) && (l_y_q == '0);
    if (l_x_q[DIFF_W-1]) begin
      vec_d.x   = -ext_x;
      vec_d.y   = -ext_y;
      vec_d.acc = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      vec_d.x   = ext_x;
      vec_d.y   = ext_y;
      vec_d.acc = '0;
    end
  end

  assign vec_o = vec_q;

endmodule

[rtl/bro_norm_cell.sv]
module bro_norm_cell
  import bro_pkg::*;
#(
  parameter int SHIFT = 1
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  bro_vec_t vec_i,
  output bro_vec_t vec_o
);

  localparam int LIM = NORM_BITS + 1 - SHIFT;
  localparam logic [CW-1:0] BOUND = CW'(64'd1 << LIM);

  logic [CW-1:0] ax, ay;
  logic          fits;
  bro_vec_t      vec_q, vec_d;

  // Scales the vector by 2^SHIFT if its larger component stays below 2^39 after the shift.
  always_comb begin
    ax    = vec_i.x[CW-1] ? -vec_i.x : vec_i.x;
    ay    = vec_i.y[CW-1] ? -vec_i.y : vec_i.y;
    fits  = (ax < BOUND) && (ay < BOUND);
    vec_d = vec_i;
    if (fits) begin
      vec_d.x = vec_i.x <<< SHIFT;
      vec_d.y = vec_i.y <<< SHIFT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_q <= '0;
    end else if (en_i) begin
      vec_q <= vec_d;
    end
  end

  assign vec_o = vec_q;

endmodule

[rtl/bro_cordic_cell.sv]
module bro_cordic_cell
  import bro_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  bro_vec_t vec_i,
  output bro_vec_t vec_o
);

  localparam logic [ACC_W-1:0] TURN = atan_turn(5'(STEP));

  logic signed [CW-1:0] dx, dy;
  bro_vec_t             vec_q, vec_d;

  always_comb begin
    dx    = vec_i.y >>> STEP;
    dy    = vec_i.x >>> STEP;
    vec_d = vec_i;
    if (!vec_i.y[CW-1]) begin
      vec_d.x   = vec_i.x + dx;
      vec_d.y   = vec_i.y - dy;
      vec_d.acc = vec_i.acc + TURN;
    end else begin
      vec_d.x   = vec_i.x - dx;
      vec_d.y   = vec_i.y + dy;
      vec_d.acc = vec_i.acc - TURN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_q <= '0;
    end else if (en_i) begin
      vec_q <= vec_d;
    end
  end

  assign vec_o = vec_q;

endmodule

[rtl/block_ridge_orientation.sv]
// Block ridge orientation from pixel gradients.
// The in_i channel takes one beat per pixel: the horizontal and vertical
// gradient and a flag on the last pixel of the block. The block sums
// 2*gx*gy and gx*gx - gy*gy, each saturating, and on the flagged pixel
// passes the two sums to a chain of cells that normalizes the vector in six
// steps and then turns it in min(ANGLE_BITS, 24) CORDIC steps, a cell each.
// The out_o channel then carries one beat holding half the angle of the sum
// vector, with 65536 standing for pi; both sums zero gives zero.
// A pixel beat is taken in every cycle unless the output stalls. The
// result passes the accumulator registers, the cells and the output register,
// and a new block can follow at once, since every cell holds its own vector.
// While a result waits with the receiver stalled, the whole chain holds
// and in_i.ready is low; it rises as soon as the result beat is taken.
// Reset clears both sums and all valid flags of the chain.
module block_ridge_orientation
  import bro_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  bro_in_if.sink    in_i,
  bro_out_if.source out_o
);

  localparam int ITERS  = (ANGLE_BITS > ATAN_LEN) ? ATAN_LEN : ANGLE_BITS;
  localparam int Q      = (ANGLE_BITS < OUT_W) ? ANGLE_BITS : OUT_W;
  localparam int CHAIN  = NORM_STAGES + ITERS;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(64'd1 << (ACC_W - 1 - Q));
  localparam logic [OUT_W-1:0] MASK = OUT_W'(17'h0FFFF << (OUT_W - Q));

  logic                    en;
  bro_vec_t                chain [CHAIN+1];
  logic [ACC_W-1:0]        rsum;
  logic                    out_valid_q;
  logic signed [OUT_W-1:0] orient_q, orient_d;

  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  bro_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_i.valid),
    .grad_x_i (in_i.grad_x),
    .grad_y_i (in_i.grad_y),
    .last_i   (in_i.last_of_block),
    .vec_o    (chain[0])
  );

  for (genvar k = 0; k < NORM_STAGES; k++) begin : g_norm
    bro_norm_cell #(
      .SHIFT (32 >> k)
    ) u_norm (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vec_i  (chain[k]),
      .vec_o  (chain[k+1])
    );
  end

  for (genvar i = 0; i < ITERS; i++) begin : g_cordic
    bro_cordic_cell #(
      .STEP (i)
    ) u_cordic (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vec_i  (chain[NORM_STAGES+i]),
      .vec_o  (chain[NORM_STAGES+i+1])
    );
  end

  always_comb begin
    rsum     = chain[CHAIN].acc + HALF;
    orient_d = chain[CHAIN].zero ? '0 : (rsum[ACC_W-1:ACC_W-OUT_W] & MASK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= chain[CHAIN].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      orient_q <= orient_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.orientation = orient_q;

endmodule

[rtl/bro_checker.sv]
module bro_checker
  import bro_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic signed [OUT_W-1:0] orientation_i
);

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Result beat dropped while the receiver stalled.");

  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(orientation_i))
    else $error("Result payload changed while the receiver stalled.");

  a_ready_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i || out_ready_i |-> in_ready_i)
    else $error("Input stalled with the output register free.");

  a_ready_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("Input taken while a result beat is stalled.");

  a_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_ready_i))
    else $error("Result appeared while the chain was held.");

endmodule

bind block_ridge_orientation bro_checker u_bro_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .orientation_i (out_o.orientation)
);
